/* sv/ssm_pkg.sv */
// Shared types and constants for the sorted squares merge block.
package ssm_pkg;

	localparam int DATA_W = 16;
	localparam int MAG_W  = 17;
	localparam int SQ_W   = 31;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     is_last;
	} ssm_in_t;

	typedef struct packed {
		logic [SQ_W-1:0] square;
		logic            last_out;
		logic            dropped;
	} ssm_out_t;

	typedef struct packed {
		logic            valid;
		logic [SQ_W-1:0] data;
	} ssm_sq_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MREAD,
		ST_MCMP,
		ST_MWAIT,
		ST_EMIT
	} ssm_state_t;

endpackage

/* sv/sorted_squares_merge_top.sv */
// Top level of the sorted squares merge block: load, two-pointer merge, emit.
//
// Usage: present one element on item with start high; it is taken at a
// rising edge where start is high and busy is low. Loading takes one cycle
// per element and busy stays low. Elements beyond DEPTH are discarded and
// every result of that set has dropped set.
// The element with is_last set (stored if room remains) starts the merge.
// With n elements stored, busy stays high through n merge steps, each a
// registered read of both pointer ends from the value RAM, then a
// magnitude compare; a wait state drains the squaring pipeline, then one
// square RAM read per cycle emits the squares smallest first.
// Each result appears on result for one cycle with done high, the results
// following one per cycle; the final result has last_out set.
// The receiver cannot stall the block.
// A new set may be started in the cycle of the final result.
// Reset clears the element count, the overflow flag and the sequencer; the
// RAM contents are not cleared.
module sorted_squares_merge_top #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ssm_pkg::ssm_in_t  item,
	output logic              done,
	output ssm_pkg::ssm_out_t result
);
	import ssm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ssm_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          overflow_q;
	logic [AW-1:0] n_m1_q, lo_q, hi_q, k_q, e_q;
	logic [AW-1:0] widx_s1;
	logic          emit_s1, last_s1, drop_s1;

	logic          accept, store_ok, step, take_right;
	logic [AW-1:0] n_m1;

	logic [1:0][AW-1:0]     val_raddr;
	logic [1:0][DATA_W-1:0] val_rdata;
	logic [0:0][AW-1:0]     sq_raddr;
	logic [0:0][SQ_W-1:0]   sq_rdata;
	ssm_sq_wr_t             sq_wr;

	assign accept   = start && (state_q == ST_IDLE);
	assign store_ok = count_q < CW'(DEPTH);
	assign n_m1     = store_ok ? count_q[AW-1:0] : AW'(DEPTH - 1);
	assign step     = (state_q == ST_MCMP);

	assign val_raddr[0] = lo_q;
	assign val_raddr[1] = hi_q;
	assign sq_raddr[0]  = e_q;

	ssm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .RD_PORTS(2), .AW(AW)) u_val_ram (
		.clk   (clk),
		.we    (accept && store_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (item.sample),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	ssm_merge_unit u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.left       (val_rdata[0]),
		.right      (val_rdata[1]),
		.take_right (take_right),
		.wr         (sq_wr)
	);

	ssm_ram #(.WIDTH(SQ_W), .DEPTH(DEPTH), .RD_PORTS(1), .AW(AW)) u_sq_ram (
		.clk   (clk),
		.we    (sq_wr.valid),
		.waddr (widx_s1),
		.wdata (sq_wr.data),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && item.is_last) begin
					state_d = ST_MREAD;
				end
			end
			ST_MREAD: state_d = ST_MCMP;
			ST_MCMP:  state_d = (k_q == n_m1_q) ? ST_MWAIT : ST_MREAD;
			ST_MWAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (e_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			emit_s1    <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			k_q        <= '0;
			e_q        <= '0;
			n_m1_q     <= '0;
		end else begin
			emit_s1 <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (item.is_last) begin
							lo_q   <= '0;
							hi_q   <= n_m1;
							k_q    <= '0;
							n_m1_q <= n_m1;
						end
					end
				end
				ST_MCMP: begin
					if (take_right) begin
						hi_q <= hi_q - AW'(1);
					end else begin
						lo_q <= lo_q + AW'(1);
					end
					k_q <= k_q + AW'(1);
				end
				ST_MWAIT: e_q <= n_m1_q;
				ST_EMIT: begin
					if (e_q == '0) begin
						count_q    <= '0;
						overflow_q <= 1'b0;
					end else begin
						e_q <= e_q - AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			widx_s1 <= k_q;
		end
		if (state_q == ST_EMIT) begin
			last_s1 <= (e_q == '0);
			drop_s1 <= overflow_q;
		end
	end

	assign done            = emit_s1;
	assign result.square   = sq_rdata[0];
	assign result.last_out = last_s1;
	assign result.dropped  = drop_s1;

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_EMIT || state_q == ST_IDLE))
		else $error("result strobe outside emit phase");

	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MCMP) |-> (lo_q <= hi_q))
		else $error("merge pointers crossed");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !store_ok) |=> overflow_q)
		else $error("discarded element not flagged");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last_out) |=> !done)
		else $error("transaction after final result");

	a_sq_write: assert property (@(posedge clk) disable iff (!arst_n)
		sq_wr.valid |-> $past(state_q == ST_MCMP))
		else $error("square write outside merge step");

endmodule

/* sv/ssm_ram.sv */
// Generic RAM: one write port, RD_PORTS registered read ports.
module ssm_ram #(
	parameter int WIDTH    = 16,
	parameter int DEPTH    = 64,
	parameter int RD_PORTS = 1,
	parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic [RD_PORTS-1:0][AW-1:0]        raddr,
	output logic [RD_PORTS-1:0][WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < RD_PORTS; p++) begin
			rdata[p] <= mem_q[raddr[p]];
		end
	end

endmodule

/* sv/ssm_merge_unit.sv */
// Shared magnitude compare and squaring pipeline for the merge pass.
module ssm_merge_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic signed [ssm_pkg::DATA_W-1:0]   left,
	input  logic signed [ssm_pkg::DATA_W-1:0]   right,
	output logic                                take_right,
	output ssm_pkg::ssm_sq_wr_t                 wr
);
	import ssm_pkg::*;

	function automatic logic [MAG_W-1:0] mag_of(logic [DATA_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {1'b0, v};
		if (v[DATA_W-1]) begin
			return MAG_W'({1'b0, ~v}) + MAG_W'(1);
		end
		return ext;
	endfunction

	logic [MAG_W-1:0]   mag_l;
	logic [MAG_W-1:0]   mag_r;
	logic [MAG_W-1:0]   mag_s1;
	logic               valid_s1;
	logic [2*MAG_W-1:0] prod;

	assign mag_l      = mag_of(left);
	assign mag_r      = mag_of(right);
	// squares order like magnitudes; tie keeps the left element
	assign take_right = mag_l < mag_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mag_s1 <= take_right ? mag_r : mag_l;
		end
	end

	assign prod     = mag_s1 * mag_s1;
	assign wr.valid = valid_s1;
	assign wr.data  = prod[SQ_W-1:0];

endmodule
